### design/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes for the positional list engine: request modes,
// result status codes and the command that steers the cell chain.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int VALUE_W  = 32;
	localparam int MODE_W   = 3;
	localparam int POS_W    = 7;
	localparam int STATUS_W = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_INS_TAIL = 3'd0,
		MODE_INS_POS  = 3'd1,
		MODE_INS_HEAD = 3'd2,
		MODE_DEL_POS  = 3'd3,
		MODE_DEL_HEAD = 3'd4,
		MODE_READ     = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE    = 2'd0,
		STAT_INVALID = 2'd1,
		STAT_EMPTY   = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_DELETE = 2'd2,
		CELL_ROTATE = 2'd3
	} cell_op_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t           op;
		logic [VALUE_W-1:0] data;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

endpackage

### design/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot. Holds one element value and, on command, takes the value of
// its left or right neighbour or the broadcast data, depending on where its
// own index lies relative to the command position.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; #(
	parameter int AW    = 6,
	parameter int INDEX = 0
) (
	input  logic               clk,
	input  cell_cmd_t          cmd,
	input  logic [AW-1:0]      pos,
	input  logic [VALUE_W-1:0] left,
	input  logic [VALUE_W-1:0] right,
	output logic [VALUE_W-1:0] q
);

	localparam logic [AW-1:0] IDX = AW'(INDEX);

	logic               at_pos;
	logic               after_pos;
	logic               before_pos;
	logic [VALUE_W-1:0] value_q;

	assign at_pos     = (IDX == pos);
	assign after_pos  = (IDX > pos);
	assign before_pos = (IDX < pos);

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CELL_HOLD: begin
				value_q <= value_q;
			end
			CELL_INSERT: begin
				if (at_pos) begin
					value_q <= cmd.data;
				end else if (after_pos) begin
					value_q <= left;
				end
			end
			CELL_DELETE: begin
				if (at_pos || after_pos) begin
					value_q <= right;
				end
			end
			CELL_ROTATE: begin
				// occupied part moves one slot towards the head, head wraps to the tail
				if (before_pos) begin
					value_q <= right;
				end else if (at_pos) begin
					value_q <= cmd.data;
				end
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

	assign q = value_q;

endmodule

### design/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to DEPTH signed 32-bit values held in a chain of cells.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (in_valid / in_stall): mode, position, value. A request is
//   taken when in_valid is high and in_stall is low.
//   Result channel (out_valid / out_stall): status, read_value, last.
//   For an insert or delete request that succeeds, the cells at and behind the
//   position shift by one slot as the request is taken, and the one result
//   appears in the output register in the cycle after the request.
//   A read-out of n elements gives n results, one per cycle while the receiver
//   does not stall, head first, with last set on the final one; the request
//   first moves the engine into its read state, from which the first result is
//   loaded into the output register. Each result rotates the occupied cells one
//   slot towards the head, so after n results the list is back in order. No
//   further request is taken until the read-out has ended.
//   While the receiver stalls, the result stays in the output register and no
//   further request is taken and no read-out step is made.
//   Reset empties the list at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module positional_list_engine import ple_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [MODE_W-1:0]         mode,
	input  logic [POS_W-1:0]          position,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [STATUS_W-1:0]       status,
	output logic signed [VALUE_W-1:0] read_value,
	output logic                      last
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	state_t              state_q;
	state_t              state_d;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_d;
	logic [CW-1:0]       rd_k_q;
	logic [CW-1:0]       rd_k_d;
	logic [CW-1:0]       count_m1;
	logic [PW-1:0]       pos_ext;
	logic [PW-1:0]       cnt_ext;
	logic [PW-1:0]       ins_pos;
	logic [PW-1:0]       del_pos;
	logic                out_free;
	logic                in_acc;
	logic                load_out;
	status_t             res_status;
	logic [VALUE_W-1:0]  res_value;
	logic                res_last;
	cell_cmd_t           cmd;
	logic [AW-1:0]       cell_pos;
	logic [VALUE_W-1:0]  cell_q [DEPTH];

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [VALUE_W-1:0]  read_value_q;
	logic                last_q;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign in_acc   = in_valid && !in_stall;

	assign count_m1 = count_q - CW'(1);
	assign pos_ext  = PW'(position);
	assign cnt_ext  = PW'(count_q);

	always_comb begin
		unique case (mode)
			MODE_INS_TAIL: ins_pos = cnt_ext;
			MODE_INS_HEAD: ins_pos = '0;
			default:       ins_pos = pos_ext;
		endcase
		del_pos = (mode == MODE_DEL_HEAD) ? '0 : pos_ext;
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		rd_k_d     = rd_k_q;
		load_out   = 1'b0;
		res_status = STAT_DONE;
		res_value  = '0;
		res_last   = 1'b1;
		cmd.op     = CELL_HOLD;
		cmd.data   = value;
		cell_pos   = '0;

		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					load_out = 1'b1;
					unique case (mode)
						MODE_INS_TAIL, MODE_INS_POS, MODE_INS_HEAD: begin
							if (ins_pos > cnt_ext) begin
								res_status = STAT_INVALID;
							end else if (count_q == CW'(DEPTH)) begin
								res_status = STAT_FULL;
							end else begin
								cmd.op   = CELL_INSERT;
								cell_pos = ins_pos[AW-1:0];
								count_d  = count_q + CW'(1);
							end
						end
						MODE_DEL_POS, MODE_DEL_HEAD: begin
							if (count_q == '0) begin
								res_status = STAT_EMPTY;
							end else if (del_pos >= cnt_ext) begin
								res_status = STAT_INVALID;
							end else begin
								cmd.op   = CELL_DELETE;
								cell_pos = del_pos[AW-1:0];
								count_d  = count_m1;
							end
						end
						MODE_READ: begin
							if (count_q == '0) begin
								res_status = STAT_EMPTY;
							end else begin
								load_out = 1'b0;
								rd_k_d   = '0;
								state_d  = S_READ;
							end
						end
						default: begin
							res_status = STAT_INVALID;
						end
					endcase
				end
			end
			S_READ: begin
				if (out_free) begin
					load_out   = 1'b1;
					res_value  = cell_q[0];
					res_last   = (rd_k_q == count_m1);
					cmd.op     = CELL_ROTATE;
					cmd.data   = cell_q[0];
					cell_pos   = count_m1[AW-1:0];
					rd_k_d     = rd_k_q + CW'(1);
					if (res_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_k_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rd_k_q  <= rd_k_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q     <= res_status;
			read_value_q <= res_value;
			last_q       <= res_last;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_W-1:0] left_val;
		logic [VALUE_W-1:0] right_val;

		if (i == 0) begin : g_first
			assign left_val = cmd.data;
		end else begin : g_mid_l
			assign left_val = cell_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_val = cell_q[i];
		end else begin : g_mid_r
			assign right_val = cell_q[i+1];
		end

		ple_cell #(
			.AW    (AW),
			.INDEX (i)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.pos   (cell_pos),
			.left  (left_val),
			.right (right_val),
			.q     (cell_q[i])
		);
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign last       = last_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("list length beyond store depth");

	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (count_q != '0) && (rd_k_q < count_q))
		else $error("read-out running on an empty list or past its end");

	a_read_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> $stable(count_q))
		else $error("list length changed during read-out");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && ((mode != MODE_READ) || (count_q == '0)) |=> out_valid_q && last_q)
		else $error("request without its single final result");

	a_no_request_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> in_stall)
		else $error("request taken during read-out");
`endif

endmodule
